// ===== hdl/bhpq_pkg.sv =====
// Shared types and constants for the binary heap priority queue.
// No dependencies; imported by the controller and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  localparam int KEY_FIELD_W = 32;
  localparam int CNT_FIELD_W = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED     = 2'd0,
    ST_POPPED       = 2'd1,
    ST_DROPPED_FULL = 2'd2,
    ST_POP_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] popped_key;
    status_t                status;
    logic [CNT_FIELD_W-1:0] entries;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bhpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/bhpq_ctrl.sv =====
// Heap sequencer: sift-up and sift-down over the key RAM, one level at a time.
// Depends on bhpq_pkg; drives the ports of one bhpq_ram instance.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ctrl #(
  parameter int DEPTH     = 128,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                order_mode,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                op,
  input  wire logic [bhpq_pkg::KEY_FIELD_W-1:0]    key,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output bhpq_pkg::result_t                        res,
  output logic                                     mem_we,
  output logic      [$clog2(DEPTH)-1:0]            mem_waddr,
  output logic      [KEY_WIDTH-1:0]                mem_wdata,
  output logic      [$clog2(DEPTH)-1:0]            mem_raddr,
  input  wire logic [KEY_WIDTH-1:0]                mem_rdata
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_UP       = 10'b00_0000_0010,
    S_UP_CMP   = 10'b00_0000_0100,
    S_POP_ROOT = 10'b00_0000_1000,
    S_POP_LAST = 10'b00_0001_0000,
    S_DN       = 10'b00_0010_0000,
    S_DN_L     = 10'b00_0100_0000,
    S_DN_R     = 10'b00_1000_0000,
    S_DN_DEC   = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos;
  logic [KEY_WIDTH-1:0] key_hold;
  logic [KEY_WIDTH-1:0] best;
  logic [AW-1:0]        best_idx;
  logic                 moved;
  logic [KEY_WIDTH-1:0] popped;
  status_t              res_status;

  logic [KEY_WIDTH-1:0]   key_ext;
  logic [KEY_FIELD_W-1:0] res_key;
  logic [CNT_FIELD_W-1:0] res_cnt;
  logic [AW-1:0]          parent;
  logic [CW:0]            lidx;
  logic [CW:0]            ridx;
  logic                   l_ok;
  logic                   r_ok;
  logic                   up_moves;

  function automatic logic better(input logic [KEY_WIDTH-1:0] a,
                                  input logic [KEY_WIDTH-1:0] b,
                                  input logic                 mode);
    logic gt;
    logic lt;
    gt = $signed(a) > $signed(b);
    lt = $signed(a) < $signed(b);
    return mode ? gt : lt;
  endfunction

  if (KEY_WIDTH > KEY_FIELD_W) begin : g_key_wide
    assign key_ext = {{(KEY_WIDTH - KEY_FIELD_W){1'b0}}, key};
    assign res_key = popped[KEY_FIELD_W-1:0];
  end else if (KEY_WIDTH == KEY_FIELD_W) begin : g_key_same
    assign key_ext = key;
    assign res_key = popped;
  end else begin : g_key_narrow
    assign key_ext = key[KEY_WIDTH-1:0];
    assign res_key = {{(KEY_FIELD_W - KEY_WIDTH){1'b0}}, popped};
  end

  if (CW > CNT_FIELD_W) begin : g_cnt_wide
    assign res_cnt = count[CNT_FIELD_W-1:0];
  end else if (CW == CNT_FIELD_W) begin : g_cnt_same
    assign res_cnt = count;
  end else begin : g_cnt_narrow
    assign res_cnt = {{(CNT_FIELD_W - CW){1'b0}}, count};
  end

  assign parent   = (pos - AW'(1)) >> 1;
  assign lidx     = ((CW + 1)'(pos) << 1) | (CW + 1)'(1);
  assign ridx     = lidx + (CW + 1)'(1);
  assign l_ok     = lidx < {1'b0, count};
  assign r_ok     = ridx < {1'b0, count};
  assign up_moves = better(key_hold, mem_rdata, order_mode);

  assign in_ready       = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.popped_key = res_key;
  assign res.status     = res_status;
  assign res.entries    = res_cnt;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = key_hold;
    mem_raddr = '0;
    case (state)
      S_UP: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr = parent;
        end
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = up_moves ? mem_rdata : key_hold;
      end
      S_POP_ROOT: begin
        mem_raddr = count[AW-1:0];
      end
      S_DN: begin
        if (l_ok) begin
          mem_raddr = lidx[AW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      S_DN_L: begin
        mem_raddr = ridx[AW-1:0];
      end
      S_DN_DEC: begin
        mem_we    = 1'b1;
        mem_wdata = moved ? best : key_hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            popped <= '0;
            if (op == OP_INSERT) begin
              if (count == CW'(DEPTH)) begin
                res_status <= ST_DROPPED_FULL;
                state      <= S_DONE;
              end else begin
                key_hold   <= key_ext;
                pos        <= count[AW-1:0];
                count      <= count + CW'(1);
                res_status <= ST_INSERTED;
                state      <= S_UP;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_POP_EMPTY;
                state      <= S_DONE;
              end else begin
                count      <= count - CW'(1);
                res_status <= ST_POPPED;
                state      <= S_POP_ROOT;
              end
            end
          end
        end
        S_UP: begin
          state <= (pos == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_moves) begin
            pos   <= parent;
            state <= S_UP;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP_ROOT: begin
          popped <= mem_rdata;
          state  <= (count == '0) ? S_DONE : S_POP_LAST;
        end
        S_POP_LAST: begin
          key_hold <= mem_rdata;
          pos      <= '0;
          state    <= S_DN;
        end
        S_DN: begin
          state <= l_ok ? S_DN_L : S_DONE;
        end
        S_DN_L: begin
          if (better(mem_rdata, key_hold, order_mode)) begin
            best     <= mem_rdata;
            best_idx <= lidx[AW-1:0];
            moved    <= 1'b1;
          end else begin
            best  <= key_hold;
            moved <= 1'b0;
          end
          state <= r_ok ? S_DN_R : S_DN_DEC;
        end
        S_DN_R: begin
          if (better(mem_rdata, best, order_mode)) begin
            best     <= mem_rdata;
            best_idx <= ridx[AW-1:0];
            moved    <= 1'b1;
          end
          state <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (moved) begin
            pos   <= best_idx;
            state <= S_DN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_dn_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN) |-> ((CW)'(pos) < count))
    else $error("sift-down position outside the heap");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_INSERT && count != CW'(DEPTH))
      |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the heap");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) |=> $stable(count))
    else $error("entry count changed without an accepted word");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("key RAM written while no operation is active");

endmodule

`default_nettype wire

// ===== hdl/binary_heap_priority_queue_unit.sv =====
// Binary heap priority queue: DEPTH signed keys in one RAM, min or max order.
// Input channel in_valid/in_ready carries one word (op, key): op 0 inserts the
// key, op 1 pops the root. Every input word gives exactly one output word
// (popped_key, status, entries) on out_valid/out_ready.
// The register order_mode is written with cfg_we/cfg_wdata; the user must do so
// only while the block is idle, the block does not enforce it. 0 keeps the
// smallest key at the root, 1 the largest.
// One word is worked on at a time, with the single RAM read port setting the
// pace. An insert climbs from the new last slot one level per step: it reads
// the parent, then writes either the parent's key down or its own key in place.
// A pop reads the root and, unless the heap is now empty, the last entry, then
// sifts down: per level it reads the left and any right child, then writes the
// better child's key or the held key into the current node.
// Full-heap inserts and empty-heap pops go to the result without RAM access.
// The result sits in an output register; a new word is accepted while it
// waits, and that word's work stalls at its end until the register frees.
// Synchronous reset empties the heap and sets min order; the RAM is not
// cleared, since only slots below the entry count are ever read.
// Depends on bhpq_pkg, bhpq_ram and bhpq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue_unit #(
  parameter int DEPTH     = 128,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_we,
  input  wire logic                                    cfg_wdata,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    op,
  input  wire logic signed [bhpq_pkg::KEY_FIELD_W-1:0] key,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed      [bhpq_pkg::KEY_FIELD_W-1:0] popped_key,
  output logic             [1:0]                       status,
  output logic             [bhpq_pkg::CNT_FIELD_W-1:0] entries
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                 order_mode;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  result_t              out_res;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg_we) begin
      order_mode <= cfg_wdata;
    end
  end

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign popped_key = out_res.popped_key;
  assign status     = out_res.status;
  assign entries    = out_res.entries;

  bhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bhpq_ctrl #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .order_mode (order_mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .key        (key),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for binary_heap_priority_queue_unit: a heap predictor
// follows every accepted word and checks each result word in order.
// Depends on bhpq_pkg and the binary_heap_priority_queue_unit RTL.
`timescale 1ns / 1ps

module tb;
  import bhpq_pkg::*;

  localparam int HEAP_DEPTH = 128;

  typedef struct {
    logic                          op;
    logic signed [KEY_FIELD_W-1:0] key;
  } heap_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic op = OP_INSERT;
  logic signed [KEY_FIELD_W-1:0] key = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic signed [KEY_FIELD_W-1:0] popped_key;
  logic [1:0] status;
  logic [CNT_FIELD_W-1:0] entries;

  heap_word_t pending_words[$];
  result_t awaited_results[$];
  logic signed [KEY_FIELD_W-1:0] heap_keys[HEAP_DEPTH];
  int heap_count = 0;
  bit order_max = 1'b0;
  bit steady = 1'b0;
  int mismatches = 0;

  binary_heap_priority_queue_unit #(
    .DEPTH(HEAP_DEPTH),
    .KEY_WIDTH(KEY_FIELD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .key(key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .popped_key(popped_key),
    .status(status),
    .entries(entries)
  );

  always #1 clk = ~clk;

  function automatic bit outranks(logic signed [KEY_FIELD_W-1:0] a,
                                  logic signed [KEY_FIELD_W-1:0] b);
    return order_max ? (a > b) : (a < b);
  endfunction

  function automatic result_t apply_to_heap(logic opc, logic signed [KEY_FIELD_W-1:0] k);
    result_t res;
    int pos;
    int up;
    int pick;
    logic signed [KEY_FIELD_W-1:0] t;
    res = '0;
    if (opc == OP_INSERT) begin
      if (heap_count < HEAP_DEPTH) begin
        pos = heap_count;
        heap_keys[pos] = k;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!outranks(heap_keys[pos], heap_keys[up])) break;
          t = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = t;
          pos = up;
        end
        heap_count++;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_DROPPED_FULL;
      end
    end else if (heap_count == 0) begin
      res.status = ST_POP_EMPTY;
    end else begin
      res.popped_key = heap_keys[0];
      heap_keys[0] = heap_keys[heap_count - 1];
      heap_count--;
      pos = 0;
      while (pos < heap_count) begin
        pick = pos;
        if (2 * pos + 1 < heap_count && outranks(heap_keys[2 * pos + 1], heap_keys[pos]))
          pick = 2 * pos + 1;
        if (2 * pos + 2 < heap_count && outranks(heap_keys[2 * pos + 2], heap_keys[pick]))
          pick = 2 * pos + 2;
        if (pick == pos) break;
        t = heap_keys[pick];
        heap_keys[pick] = heap_keys[pos];
        heap_keys[pos] = t;
        pos = pick;
      end
      res.status = ST_POPPED;
    end
    res.entries = CNT_FIELD_W'(heap_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_FIELD_W-1:0] got,
                                 logic [KEY_FIELD_W-1:0] want);
    if (mismatches < 100)
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(logic opc, logic [KEY_FIELD_W-1:0] k);
    heap_word_t w;
    w.op = opc;
    w.key = k;
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic write_order(bit mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_max = mode;
  endtask

  always @(posedge clk) begin : driver
    bit load;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      load = !in_valid;
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_to_heap(op, key));
        load = 1'b1;
      end
      if (load) begin
        if (pending_words.size() > 0 && (steady || $urandom_range(0, 99) >= 14)) begin
          in_valid <= 1'b1;
          op <= pending_words[0].op;
          key <= pending_words[0].key;
          pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected word", popped_key, '0);
        end else begin
          want = awaited_results.pop_front();
          if (popped_key !== want.popped_key)
            report_mismatch("popped_key", popped_key, want.popped_key);
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (entries !== want.entries)
            report_mismatch("entries", 32'(entries), 32'(want.entries));
        end
      end
      out_ready <= steady || $urandom_range(0, 99) >= 14;
    end
  end

  initial begin : stimulus
    int issued;
    int p;
    int len;
    int pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Min order: empty pop, extreme keys, duplicates, then partial drain.
    write_order(1'b0);
    @(negedge clk);
    queue_word(OP_POP, 32'h1234_5678);
    queue_word(OP_INSERT, 32'h7fff_ffff);
    queue_word(OP_INSERT, 32'h8000_0000);
    queue_word(OP_INSERT, 32'h0000_0000);
    queue_word(OP_INSERT, 32'hffff_ffff);
    queue_word(OP_INSERT, 32'h0000_0001);
    queue_word(OP_INSERT, 32'hffff_ffff);
    queue_word(OP_POP, 32'h0);
    queue_word(OP_POP, 32'h0);
    queue_word(OP_POP, 32'h0);
    wait_idle();

    // Switch to max order with keys still held; the heap is not rebuilt.
    write_order(1'b1);
    @(negedge clk);
    queue_word(OP_INSERT, 32'h5555_5555);
    queue_word(OP_INSERT, 32'haaaa_aaaa);
    repeat (6) queue_word(OP_POP, 32'hffff_ffff);
    wait_idle();

    issued = 0;
    p = 0;
    while (issued < 1450) begin
      case (p % 3)
        0: begin
          len = $urandom_range(170, 200);
          pct = 95;
        end
        1: begin
          len = $urandom_range(90, 150);
          pct = 55;
        end
        default: begin
          len = $urandom_range(90, 150);
          pct = 15;
        end
      endcase
      if (len > 1450 - issued)
        len = 1450 - issued;
      write_order(1'($urandom_range(0, 1)));
      steady = (p == 1);
      @(negedge clk);
      repeat (len)
        queue_word(($urandom_range(0, 99) < pct) ? OP_INSERT : OP_POP, pick_key());
      issued += len;
      p++;
      wait_idle();
    end

    steady = 1'b0;
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
